### hdl/plpf_pkg.sv
// Shared types and constants of the point light pixel fill block.
package plpf_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int DEN_W = 43;           // clamped denominator, Q.32, at most 2^42
   localparam int DVS_W = DEN_W + 1;    // divisor 2*den
   localparam int KF_W = 24;            // k in Q16.8
   localparam int REM_W = DVS_W + KF_W; // partial remainder
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [DEN_W-1:0] DEN_LIMIT = DEN_W'(64'd1 << 42);
   localparam logic [KF_W-1:0] KF_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIGHT_X = 3'd0,
      REG_LIGHT_Y = 3'd1,
      REG_SCALE_SQ = 3'd2,
      REG_LIGHT_BIAS = 3'd3,
      REG_COLOR_RED = 3'd4,
      REG_COLOR_GREEN = 3'd5,
      REG_COLOR_BLUE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic lit;
      logic sat;
      logic [31:0] old_pixel;
      logic [REM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [KF_W-1:0] quo;
   } div_item_type;

endpackage

### hdl/plpf_div_stage.sv
// One restoring division step of the reciprocal pipeline.
module plpf_div_stage (
   input logic clock,
   input logic reset,
   input logic enable,
   input plpf_pkg::div_item_type item_in,
   output plpf_pkg::div_item_type item_out
);
   import plpf_pkg::*;

   div_item_type item_ff, item_in_c;
   logic [REM_W-1:0] shifted_dvs;
   logic [REM_W-1:0] diff;
   logic take;

   always_comb begin
      shifted_dvs = REM_W'(item_in.dvs) << (KF_W - 1);
      take = item_in.rem >= shifted_dvs;
      diff = take ? item_in.rem - shifted_dvs : item_in.rem;
      item_in_c = item_in;
      item_in_c.rem = diff << 1;
      item_in_c.quo = {item_in.quo[KF_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (enable) begin
         item_ff <= item_in_c;
      end
   end

   assign item_out = item_ff;
endmodule

### hdl/point_light_pixel_fill.sv
// Top level of the point light pixel fill pipeline.
//
// Shades unlit pixels with one point light. Each item on the req_ channel
// carries a pixel position and its current packed value; each item on the
// rsp_ channel carries the new packed value, in the same order. A nonzero
// pixel passes unchanged, a zero pixel gets red, green, blue scaled by
// k/256, where k = 1/(scale_sq*dist^2 + light bias), and alpha 255 - k.
// Six stages form the denominator, one checks reciprocal saturation, 24
// stages produce one quotient bit each of the rounded reciprocal, and two
// scale and round colors. Throughput is one item per cycle while rsp_ready
// holds; the bit-serial divider chain sets the depth, not the rate.
// All stages advance together whenever the output register is empty or
// being taken, so a stalled receiver holds every item in place and
// req_ready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults.
// Write the csr_ registers only while no item is in flight.
module point_light_pixel_fill #(
   parameter int COORD_BITS = plpf_pkg::COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [COORD_BITS-1:0] req_pixel_x,
   input logic [COORD_BITS-1:0] req_pixel_y,
   input logic [31:0] req_old_pixel,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [31:0] rsp_new_pixel,
   input logic csr_write_enable,
   input logic [plpf_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [plpf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import plpf_pkg::*;

   // signed difference width, magnitude width, square and product widths
   localparam int DW = ((COORD_BITS + 5 > 16) ? COORD_BITS + 5 : 16) + 1;
   localparam int SQ_W = 2 * DW;
   localparam int SUM_W = SQ_W + 1;
   localparam int PROD_W = SUM_W + 32;
   localparam int ADD_W = PROD_W + 1;

   // configuration registers
   logic [15:0] light_x_ff, light_y_ff;
   logic [31:0] scale_sq_ff, light_bias_ff;
   logic [7:0] color_red_ff, color_green_ff, color_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         scale_sq_ff <= 32'h0100_0000;
         light_bias_ff <= 32'h0001_0000;
         color_red_ff <= 8'd255;
         color_green_ff <= 8'd255;
         color_blue_ff <= 8'd255;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LIGHT_X: light_x_ff <= csr_write_data[15:0];
            REG_LIGHT_Y: light_y_ff <= csr_write_data[15:0];
            REG_SCALE_SQ: scale_sq_ff <= csr_write_data[31:0];
            REG_LIGHT_BIAS: light_bias_ff <= csr_write_data[31:0];
            REG_COLOR_RED: color_red_ff <= csr_write_data[7:0];
            REG_COLOR_GREEN: color_green_ff <= csr_write_data[7:0];
            REG_COLOR_BLUE: color_blue_ff <= csr_write_data[7:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // advance the whole pipeline when the output slot is free or taken
   logic advance;
   logic rsp_valid_ff;
   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1: signed differences in Q.4
   logic s1_valid_ff, s1_lit_ff;
   logic [31:0] s1_old_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff;
   logic signed [DW-1:0] s1_dx_in, s1_dy_in;

   always_comb begin
      s1_dx_in = DW'($signed(light_x_ff)) - $signed(DW'({req_pixel_x, 4'b0}));
      s1_dy_in = DW'($signed(light_y_ff)) - $signed(DW'({req_pixel_y, 4'b0}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s1_lit_ff <= (req_old_pixel == 32'd0);
         s1_old_ff <= req_old_pixel;
         s1_dx_ff <= s1_dx_in;
         s1_dy_ff <= s1_dy_in;
      end
   end

   // stage 2: magnitudes
   logic s2_valid_ff, s2_lit_ff;
   logic [31:0] s2_old_ff;
   logic [DW-1:0] s2_ax_ff, s2_ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
         s2_lit_ff <= s1_lit_ff;
         s2_old_ff <= s1_old_ff;
         s2_ax_ff <= s1_dx_ff[DW-1] ? DW'(-s1_dx_ff) : DW'(s1_dx_ff);
         s2_ay_ff <= s1_dy_ff[DW-1] ? DW'(-s1_dy_ff) : DW'(s1_dy_ff);
      end
   end

   // stage 3: squares
   logic s3_valid_ff, s3_lit_ff;
   logic [31:0] s3_old_ff;
   logic [SQ_W-1:0] s3_sqx_ff, s3_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
         s3_lit_ff <= s2_lit_ff;
         s3_old_ff <= s2_old_ff;
         s3_sqx_ff <= SQ_W'(s2_ax_ff) * SQ_W'(s2_ax_ff);
         s3_sqy_ff <= SQ_W'(s2_ay_ff) * SQ_W'(s2_ay_ff);
      end
   end

   // stage 4: sum of squares, Q.8
   logic s4_valid_ff, s4_lit_ff;
   logic [31:0] s4_old_ff;
   logic [SUM_W-1:0] s4_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
         s4_lit_ff <= s3_lit_ff;
         s4_old_ff <= s3_old_ff;
         s4_sum_ff <= SUM_W'(s3_sqx_ff) + SUM_W'(s3_sqy_ff);
      end
   end

   // stage 5: scale by scale_sq, Q.32
   logic s5_valid_ff, s5_lit_ff;
   logic [31:0] s5_old_ff;
   logic [PROD_W-1:0] s5_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
         s5_lit_ff <= s4_lit_ff;
         s5_old_ff <= s4_old_ff;
         s5_prod_ff <= PROD_W'(s4_sum_ff) * PROD_W'(scale_sq_ff);
      end
   end

   // stage 6: add the intensity term and clamp at 2^42
   logic s6_valid_ff, s6_lit_ff;
   logic [31:0] s6_old_ff;
   logic [DEN_W-1:0] s6_den_ff;
   logic [ADD_W-1:0] s6_total;

   assign s6_total = ADD_W'(s5_prod_ff) + (ADD_W'(light_bias_ff) << 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
         s6_lit_ff <= s5_lit_ff;
         s6_old_ff <= s5_old_ff;
         s6_den_ff <= (s6_total > ADD_W'(DEN_LIMIT)) ? DEN_LIMIT : s6_total[DEN_W-1:0];
      end
   end

   // stage 7: kf = (2^41 + den) / (2 den); saturate when it reaches 2^24
   div_item_type div_head_ff, div_head_in;
   logic [DVS_W-1:0] numer, dvs;

   always_comb begin
      numer = (DVS_W'(1) << 41) + DVS_W'(s6_den_ff);
      dvs = {s6_den_ff, 1'b0};
      div_head_in.valid = s6_valid_ff;
      div_head_in.lit = s6_lit_ff;
      div_head_in.old_pixel = s6_old_ff;
      div_head_in.sat = REM_W'(numer) >= (REM_W'(dvs) << KF_W);
      div_head_in.rem = REM_W'(numer);
      div_head_in.dvs = dvs;
      div_head_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_head_ff.valid <= 1'b0;
      end else if (advance) begin
         div_head_ff <= div_head_in;
      end
   end

   // one quotient bit per stage
   div_item_type chain [KF_W+1];
   assign chain[0] = div_head_ff;

   for (genvar i = 0; i < KF_W; i++) begin : g_div
      plpf_div_stage u_step (
         .clock(clock),
         .reset(reset),
         .enable(advance),
         .item_in(chain[i]),
         .item_out(chain[i+1])
      );
   end

   // color products and alpha operand
   div_item_type tail;
   logic [KF_W-1:0] kf;
   assign tail = chain[KF_W];
   assign kf = tail.sat ? KF_MAX : tail.quo;

   logic f1_valid_ff, f1_lit_ff;
   logic [31:0] f1_old_ff;
   logic [31:0] f1_red_ff, f1_green_ff, f1_blue_ff;
   logic [KF_W:0] f1_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= tail.valid;
         f1_lit_ff <= tail.lit;
         f1_old_ff <= tail.old_pixel;
         f1_red_ff <= 32'(color_red_ff) * 32'(kf);
         f1_green_ff <= 32'(color_green_ff) * 32'(kf);
         f1_blue_ff <= 32'(color_blue_ff) * 32'(kf);
         // 255*256 - kf, offset by 2^24 to stay nonnegative
         f1_alpha_ff <= (KF_W+1)'(65280) + (KF_W+1)'(1 << KF_W) - (KF_W+1)'(kf);
      end
   end

   // round half to even, keep the low byte
   function automatic logic [7:0] round_col(input logic [31:0] p);
      logic up;
      up = (p[15:0] > 16'h8000) || ((p[15:0] == 16'h8000) && p[16]);
      return p[23:16] + 8'(up);
   endfunction

   logic alpha_up;
   logic [7:0] alpha_byte;
   assign alpha_up = (f1_alpha_ff[7:0] > 8'h80) || ((f1_alpha_ff[7:0] == 8'h80) && f1_alpha_ff[8]);
   assign alpha_byte = f1_alpha_ff[15:8] + 8'(alpha_up);

   // output register
   logic [31:0] rsp_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f1_valid_ff;
         rsp_pixel_ff <= f1_lit_ff
            ? {round_col(f1_red_ff), round_col(f1_green_ff), round_col(f1_blue_ff), alpha_byte}
            : f1_old_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_pixel = rsp_pixel_ff;
endmodule
